FILE: sv/iht_pkg.sv
`timescale 1ns / 1ps

package iht_pkg;

    localparam int TS_W    = 64;
    localparam int SEL_W   = 4;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BIN_LIMIT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_SPAN       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BINNING_ENABLE = 2'd2;

    localparam logic REQ_MARK = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_DIFF  = 8'b0000_0100,
        S_CHECK = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_READ  = 8'b0010_0000,
        S_WAIT  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic clear;
        logic idle;
        logic diff;
        logic check;
        logic div_step;
        logic read;
        logic take;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic in_valid;
        logic is_read;
        logic started;
        logic bin_off;
        logic clamp;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

FILE: sv/iht_if.sv
`timescale 1ns / 1ps

interface iht_req_if import iht_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [TS_W-1:0]  timestamp;
    logic [SEL_W-1:0] bin_select;

    modport source (output valid, output req_type, output timestamp, output bin_select,
                    input ready);
    modport sink   (input valid, input req_type, input timestamp, input bin_select,
                    output ready);
endinterface

interface iht_rsp_if import iht_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             interval_valid;
    logic [TS_W-1:0]  interval;
    logic [TS_W-1:0]  max_interval;
    logic [TS_W-1:0]  sample_count;
    logic [TS_W-1:0]  interval_total;
    logic [SEL_W-1:0] bin_index;
    logic [TS_W-1:0]  bin_count;

    modport source (output valid, output interval_valid, output interval,
                    output max_interval, output sample_count, output interval_total,
                    output bin_index, output bin_count, input ready);
    modport sink   (input valid, input interval_valid, input interval,
                    input max_interval, input sample_count, input interval_total,
                    input bin_index, input bin_count, output ready);
endinterface

FILE: sv/iht_ram.sv
`timescale 1ns / 1ps

module iht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/iht_ctrl.sv
`timescale 1ns / 1ps

module iht_ctrl import iht_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (st.clr_last) state_next = S_IDLE;
            S_IDLE:  if (st.in_valid) state_next = S_DIFF;
            S_DIFF:
            begin
                if (st.is_read)
                    state_next = S_READ;
                else if (!st.started)
                    state_next = S_DONE;
                else
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (st.bin_off)
                    state_next = S_DONE;
                else if (st.clamp)
                    state_next = S_READ;
                else
                    state_next = S_DIV;
            end
            S_DIV:   if (st.div_last) state_next = S_READ;
            S_READ:  state_next = S_WAIT;
            S_WAIT:  state_next = S_DONE;
            S_DONE:  if (st.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd          = '0;
        cmd.clear    = (state_reg == S_CLEAR);
        cmd.idle     = (state_reg == S_IDLE);
        cmd.diff     = (state_reg == S_DIFF);
        cmd.check    = (state_reg == S_CHECK);
        cmd.div_step = (state_reg == S_DIV);
        cmd.read     = (state_reg == S_READ);
        cmd.take     = (state_reg == S_WAIT);
        cmd.load     = (state_reg == S_DONE) && st.out_free;
    end

endmodule

FILE: sv/iht_dp.sv
`timescale 1ns / 1ps

module iht_dp import iht_pkg::*; #(
    parameter int HIST_BINS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output status_t              st,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    iht_req_if.sink              req,
    iht_rsp_if.source            rsp
);

    localparam int IDX_W = $clog2(HIST_BINS);
    localparam int QW    = (IDX_W > SEL_W) ? IDX_W : SEL_W;
    localparam logic [QW-1:0]    LAST_Q   = QW'(HIST_BINS - 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HIST_BINS - 1);

    // configuration
    logic [TS_W-1:0] bin_limit_reg;
    logic [TS_W-1:0] bin_span_reg;
    logic            binning_enable_reg;

    // running state
    logic            started_reg;
    logic [TS_W-1:0] prev_reg;
    logic [TS_W-1:0] max_reg;
    logic [TS_W-1:0] count_reg;
    logic [TS_W-1:0] sum_reg;

    // per-item work registers
    logic             type_reg;
    logic [TS_W-1:0]  ts_reg;
    logic             valid_reg;
    logic [TS_W-1:0]  diff_reg;
    logic [TS_W-1:0]  rem_reg;
    logic [QW-1:0]    q_reg;
    logic [IDX_W-1:0] step_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [TS_W-1:0]  cnt_reg;
    logic [IDX_W-1:0] clr_reg;

    // result register
    logic             out_valid_reg;
    logic             o_ivalid_reg;
    logic [TS_W-1:0]  o_interval_reg;
    logic [TS_W-1:0]  o_max_reg;
    logic [TS_W-1:0]  o_count_reg;
    logic [TS_W-1:0]  o_sum_reg;
    logic [SEL_W-1:0] o_index_reg;
    logic [TS_W-1:0]  o_cnt_reg;

    logic             accept;
    logic             clamp;
    logic             div_bit;
    logic [IDX_W-1:0] idx_clamp;
    logic [QW-1:0]    idx_wide;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [TS_W-1:0]  ram_wdata;
    logic [TS_W-1:0]  ram_rdata;

    assign accept    = cmd.idle && req.valid;
    assign req.ready = cmd.idle;

    assign clamp     = (diff_reg >= bin_limit_reg) || (bin_span_reg == '0)
                    || ((diff_reg >> IDX_W) >= bin_span_reg);
    assign div_bit   = (rem_reg >> step_reg) >= bin_span_reg;
    assign idx_clamp = (q_reg >= LAST_Q) ? LAST_IDX : IDX_W'(q_reg);
    assign idx_wide  = QW'(idx_reg);

    assign ram_we    = cmd.clear || (cmd.take && (type_reg == REQ_MARK));
    assign ram_waddr = cmd.clear ? clr_reg : idx_reg;
    assign ram_wdata = cmd.clear ? '0 : (ram_rdata + 64'd1);

    iht_ram #(
        .WIDTH (TS_W),
        .DEPTH (HIST_BINS)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.read),
        .raddr (idx_clamp),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        st          = '0;
        st.clr_last = (clr_reg == LAST_IDX);
        st.in_valid = req.valid;
        st.is_read  = (type_reg == REQ_READ);
        st.started  = started_reg;
        st.bin_off  = !binning_enable_reg;
        st.clamp    = clamp;
        st.div_last = (step_reg == '0);
        st.out_free = !out_valid_reg || rsp.ready;
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_limit_reg      <= '0;
            bin_span_reg       <= 64'd1;
            binning_enable_reg <= 1'b1;
            started_reg        <= 1'b0;
            prev_reg           <= '0;
            max_reg            <= '0;
            count_reg          <= '0;
            sum_reg            <= '0;
            clr_reg            <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BIN_LIMIT:      bin_limit_reg      <= cfg_data;
                    REG_BIN_SPAN:       bin_span_reg       <= cfg_data;
                    REG_BINNING_ENABLE: binning_enable_reg <= cfg_data[0];
                    default:            ;
                endcase
            end
            if (cmd.clear)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.diff && (type_reg == REQ_MARK))
            begin
                started_reg <= 1'b1;
                prev_reg    <= ts_reg;
            end
            if (cmd.check)
            begin
                if (diff_reg > max_reg)
                    max_reg <= diff_reg;
                count_reg <= count_reg + 64'd1;
                sum_reg   <= sum_reg + diff_reg;
            end
            if (cmd.load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // work registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg  <= req.req_type;
            ts_reg    <= req.timestamp;
            q_reg     <= QW'(req.bin_select);
            valid_reg <= 1'b0;
            diff_reg  <= '0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end
        if (cmd.diff && (type_reg == REQ_MARK) && started_reg)
        begin
            diff_reg  <= ts_reg - prev_reg;
            valid_reg <= 1'b1;
        end
        if (cmd.check)
        begin
            q_reg    <= clamp ? LAST_Q : '0;
            rem_reg  <= diff_reg;
            step_reg <= IDX_W'(IDX_W - 1);
        end
        if (cmd.div_step)
        begin
            if (div_bit)
                rem_reg <= rem_reg - (bin_span_reg << step_reg);
            if (QW > 1)
                q_reg <= {q_reg[QW-2:0], div_bit};
            else
                q_reg <= QW'(div_bit);
            step_reg <= step_reg - 1'b1;
        end
        if (cmd.read)
            idx_reg <= idx_clamp;
        if (cmd.take)
            cnt_reg <= (type_reg == REQ_MARK) ? (ram_rdata + 64'd1) : ram_rdata;
        if (cmd.load)
        begin
            o_ivalid_reg   <= valid_reg;
            o_interval_reg <= diff_reg;
            o_max_reg      <= max_reg;
            o_count_reg    <= count_reg;
            o_sum_reg      <= sum_reg;
            o_index_reg    <= idx_wide[SEL_W-1:0];
            o_cnt_reg      <= cnt_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.interval_valid = o_ivalid_reg;
    assign rsp.interval       = o_interval_reg;
    assign rsp.max_interval   = o_max_reg;
    assign rsp.sample_count   = o_count_reg;
    assign rsp.interval_total = o_sum_reg;
    assign rsp.bin_index      = o_index_reg;
    assign rsp.bin_count      = o_cnt_reg;

endmodule

FILE: sv/interval_histogram_timer.sv
`timescale 1ns / 1ps

// channel  dir  handshake        payload
// -------  ---  ---------------  ------------------------------------------------
// req      in   valid / ready    req_type, timestamp, bin_select
// rsp      out  valid / ready    interval_valid, interval, max_interval,
//                                sample_count, interval_total, bin_index, bin_count
// cfg      in   cfg_we           cfg_index, cfg_data (bin_limit, bin_span, binning_enable)
//
// one item at a time; a binned mark runs the one-bit-per-cycle restoring divider
// that finds interval / bin_span, then the histogram read-modify-write on the bin ram;
// a mark sent straight to the last bin skips the divider, a read goes to the bin read,
// and a statistics-only mark and a first mark make no access to the bin ram
// after reset a clearing pass zeroes the histogram, no item taken
// the result sits in an output register; the next item is accepted while it waits,
// and only the final load stalls on a full output register

module interval_histogram_timer import iht_pkg::*; #(
    parameter int HIST_BINS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    iht_req_if.sink              req,
    iht_rsp_if.source            rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // command and status between sequencer and datapath
    cmd_t    cmd;
    status_t st;

    // sequencer: clear sweep, dispatch, divide steps, bin update
    iht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    // datapath: statistics, divider, histogram ram, output register
    iht_dp #(
        .HIST_BINS (HIST_BINS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

endmodule
